// ----- design/rp8u_pkg.sv -----
// Package for the raw packed to 8-bit unpacker.
// Holds the layout codes, the decode result type and the group length helper.
// No dependencies.
`timescale 1ns / 1ps

package rp8u_pkg;

  typedef enum logic [2:0] {
    LAYOUT_U12       = 3'd0,
    LAYOUT_12MIPI    = 3'd1,
    LAYOUT_12PACKED  = 3'd2,
    LAYOUT_12SPACKED = 3'd3,
    LAYOUT_U10       = 3'd4,
    LAYOUT_10SPACKED = 3'd5,
    LAYOUT_10MIPI    = 3'd6,
    LAYOUT_UNUSED    = 3'd7
  } layout_t;

  // Decoder outcome for one byte
  typedef struct packed {
    logic       emit;
    logic [7:0] pixel;
  } decode_t;

  function automatic logic [2:0] group_length(input logic [2:0] layout);
    logic [2:0] len;
    case (layout)
      LAYOUT_U12, LAYOUT_U10:                         len = 3'd2;
      LAYOUT_12MIPI, LAYOUT_12PACKED, LAYOUT_12SPACKED: len = 3'd3;
      LAYOUT_10SPACKED, LAYOUT_10MIPI:                len = 3'd5;
      default:                                        len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- design/rp8u_decode.sv -----
// Byte decoder of the unpacker: group phase and previous-byte state plus
// the combinational pixel extraction. Depends on rp8u_pkg.
`timescale 1ns / 1ps

module rp8u_decode import rp8u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] layout,
  input  logic [7:0] byte_in,
  input  logic       start_in,
  input  logic       advance,
  output decode_t    result
);

  logic [2:0] byte_phase;
  logic [2:0] byte_phase_next;
  logic [7:0] held_byte;
  logic [2:0] len;
  logic [2:0] ph;
  logic [3:0] ph_inc;
  logic [7:0] p;
  logic [7:0] b;

  assign len    = group_length(layout);
  assign ph     = (start_in || (byte_phase >= len)) ? 3'd0 : byte_phase;
  assign ph_inc = {1'b0, ph} + 4'd1;
  assign byte_phase_next = (ph_inc >= {1'b0, len}) ? 3'd0 : ph_inc[2:0];
  assign p = held_byte;
  assign b = byte_in;

  always_comb begin
    result = '{emit: 1'b0, pixel: 8'd0};
    case (layout)
      LAYOUT_U12: begin
        if (ph == 3'd1) result = '{1'b1, {b[3:0], p[7:4]}};
      end
      LAYOUT_12MIPI: begin
        if (ph <= 3'd1) result = '{1'b1, b};
      end
      LAYOUT_12PACKED: begin
        if (ph == 3'd0 || ph == 3'd2) result = '{1'b1, b};
      end
      LAYOUT_12SPACKED: begin
        if (ph == 3'd1)      result = '{1'b1, {b[3:0], p[7:4]}};
        else if (ph == 3'd2) result = '{1'b1, b};
      end
      LAYOUT_U10: begin
        if (ph == 3'd1) result = '{1'b1, {b[1:0], p[7:2]}};
      end
      LAYOUT_10SPACKED: begin
        case (ph)
          3'd1:    result = '{1'b1, {b[1:0], p[7:2]}};
          3'd2:    result = '{1'b1, {b[3:0], p[7:4]}};
          3'd3:    result = '{1'b1, {b[5:0], p[7:6]}};
          3'd4:    result = '{1'b1, b};
          default: result = '{1'b0, 8'd0};
        endcase
      end
      LAYOUT_10MIPI: begin
        if (ph <= 3'd3) result = '{1'b1, b};
      end
      default: result = '{1'b0, 8'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= 3'd0;
      held_byte  <= 8'd0;
    end else if (advance) begin
      byte_phase <= byte_phase_next;
      held_byte  <= b;
    end
  end

endmodule

// ----- design/rp8u_out_reg.sv -----
// Result register of the unpacker: holds one pixel until the sink takes it.
// Depends on rp8u_pkg.
`timescale 1ns / 1ps

module rp8u_out_reg import rp8u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  decode_t    result,
  input  logic       pixel_stall,
  output logic       pixel_valid,
  output logic [7:0] pixel
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (load && result.emit) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && result.emit) begin
      pixel <= result.pixel;
    end
  end

endmodule

// ----- design/raw_packed_to_8bit_unpacker.sv -----
// Top level of the raw packed to 8-bit unpacker.
// Instantiates rp8u_decode and rp8u_out_reg; depends on rp8u_pkg.
`timescale 1ns / 1ps

// Takes a raw camera line one byte per item on the data channel and gives
// the top eight bits of each decoded pixel on the pixel channel. The
// source_layout register picks the packing: 0 u12, 1 12-bit MIPI,
// 2 12-bit packed, 3 12-bit spacked, 4 u10, 5 10-bit spacked, 6 10-bit MIPI;
// code 7 gives no pixels. line_start on a byte makes it byte 0 of a new
// group. Each byte passes an input register, then the decoder, then the
// pixel register, so a pixel is offered once its last byte leaves the input
// register. One byte is accepted every cycle while the sink keeps up. While
// the pixel register is full and the sink stalls, a byte in the input
// register that would emit a pixel is held and the data channel stalls in
// that same cycle; a byte that emits nothing still advances. Write
// source_layout only while the block is idle; a write keeps the group phase
// and the held byte.
module raw_packed_to_8bit_unpacker import rp8u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       source_layout_we,
  input  logic [2:0] source_layout_wdata,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       line_start,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output logic [7:0] pixel
);

  logic [2:0] layout;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;
  decode_t    result;

  // Layout register, reset to u12
  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= LAYOUT_U12;
    end else if (source_layout_we) begin
      layout <= source_layout_wdata;
    end
  end

  // Advance the input register when its byte yields nothing, or the
  // pixel register is free or being drained this cycle.
  assign advance    = in_valid && (!result.emit || !pixel_valid || !pixel_stall);
  assign data_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!data_stall) begin
      in_valid <= data_valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      in_byte  <= data_byte;
      in_start <= line_start;
    end
  end

  rp8u_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .layout   (layout),
    .byte_in  (in_byte),
    .start_in (in_start),
    .advance  (advance),
    .result   (result)
  );

  rp8u_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .result      (result),
    .pixel_stall (pixel_stall),
    .pixel_valid (pixel_valid),
    .pixel       (pixel)
  );

  // A full, stalled pixel register must block a byte that would emit
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_valid && result.emit && pixel_valid && pixel_stall) |-> !advance)
    else $error("pixel register overwritten while stalled");

  // The unused layout code never produces a pixel
  a_code7_silent: assert property (@(posedge clk) disable iff (rst)
    (layout == LAYOUT_UNUSED) |-> !result.emit)
    else $error("pixel emitted under unused layout");

  // A pixel appears only from an emitting byte that advanced
  a_pixel_source: assert property (@(posedge clk) disable iff (rst)
    (!pixel_valid ##1 pixel_valid) |-> $past(advance && result.emit))
    else $error("pixel valid without a decoded byte");

  // Reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_valid && !pixel_valid))
    else $error("registers not empty after reset");

endmodule
